// File: hw/rtl/mvsm_pkg.sv
// ---------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants of the multi-voice sample mixer.
// ---------------------------------------------------------------------------
package mvsm_pkg;
	localparam int VOICE_SLOTS      = 16;
	localparam int SLOT_BITS        = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
	localparam int SAMPLE_ADDR_BITS = 16;
	localparam int LEN_BITS         = 17;
	localparam int ACC_BITS         = 40;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_MIX   = 2'd2;

	localparam logic [1:0] ST_MIXED  = 2'd0;
	localparam logic [1:0] ST_START  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_LAYOUT = 2'd3;

	localparam logic [2:0] CH_MONO   = 3'd1;
	localparam logic [2:0] CH_STEREO = 3'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_LEFT,
		S_RIGHT,
		S_DONE,
		S_OUT
	} state_t;

	// voice descriptor as held in the voice memory
	typedef struct packed {
		logic [SAMPLE_ADDR_BITS-1:0] start;
		logic [LEN_BITS-1:0]         length;
		logic [LEN_BITS-1:0]         cursor;
	} voice_t;

	// truncate toward zero: (s * vol) / 32768
	function automatic logic signed [ACC_BITS-1:0] scale(input logic signed [15:0] s,
		input logic [15:0] vol);
		logic signed [32:0] p;
		logic signed [32:0] b;
		begin
			p = s * $signed({1'b0, vol});
			b = p + ((p < 0) ? 33'sd32767 : 33'sd0);
			scale = ACC_BITS'(b >>> 15);
		end
	endfunction

	function automatic logic [31:0] sat32(input logic signed [ACC_BITS-1:0] v);
		begin
			if (v > ACC_BITS'(64'sh7FFFFFFF))
				sat32 = 32'h7FFFFFFF;
			else if (v < -(ACC_BITS'(64'sh80000000)))
				sat32 = 32'h80000000;
			else
				sat32 = v[31:0];
		end
	endfunction
endpackage

// File: hw/rtl/mvsm_sample_ram.sv
// ---------------------------------------------------------------------------
// mvsm_sample_ram
// Sample word memory, one port, registered read.
// ---------------------------------------------------------------------------
module mvsm_sample_ram
	import mvsm_pkg::*;
(
	input  logic                        clk,
	input  logic                        we,
	input  logic [SAMPLE_ADDR_BITS-1:0] addr,
	input  logic [15:0]                 wdata,
	output logic [15:0]                 rdata
);
	logic [15:0] mem [2**SAMPLE_ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: hw/rtl/mvsm_voice_ram.sv
// ---------------------------------------------------------------------------
// mvsm_voice_ram
// Voice descriptor memory, one port, registered read.
// ---------------------------------------------------------------------------
module mvsm_voice_ram
	import mvsm_pkg::*;
(
	input  logic                 clk,
	input  logic                 we,
	input  logic [SLOT_BITS-1:0] addr,
	input  voice_t               wdata,
	output voice_t               rdata
);
	voice_t mem [VOICE_SLOTS];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: hw/rtl/multi_voice_sample_mixer.sv
// A write gives no result; a start result is valid in the cycle after its request; a mix
// result walks every slot through S_READ and S_DONE, with S_LEFT and S_RIGHT between them
// for a busy slot, the single sample memory port reading each busy voice in turn.
// Throughput: one request at a time; the next is taken the cycle after the result leaves.
// Reset clears the busy/stereo/loop flags and master volume; memories are not cleared.
// ---------------------------------------------------------------------------
// multi_voice_sample_mixer
// Sample memory, voice table and frame mixer with an APB volume register.
// ---------------------------------------------------------------------------
module multi_voice_sample_mixer
	import mvsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [0:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [15:0]        address,
	input  logic signed [15:0] sample_value,
	input  logic [16:0]        clip_length,
	input  logic [2:0]         channel_count,
	input  logic               looping,
	input  logic signed [31:0] bed_left,
	input  logic signed [31:0] bed_right,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] mix_left,
	output logic signed [31:0] mix_right
);
	logic [15:0] vol_q;
	state_t state_q, state_d;
	logic [VOICE_SLOTS-1:0] busy_q, stereo_q, loops_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic signed [ACC_BITS-1:0] acc_l_q, acc_r_q;
	voice_t vw;
	voice_t vr;
	logic v_we;
	logic [SLOT_BITS-1:0] v_addr;
	logic s_we;
	logic [SAMPLE_ADDR_BITS-1:0] s_addr;
	logic [15:0] s_rd;
	logic [LEN_BITS:0] cur_next;
	logic cur_end;
	logic signed [ACC_BITS-1:0] sc;
	logic [SLOT_BITS-1:0] free_slot;
	logic any_free;
	logic layout_ok;
	logic accept;
	logic last_slot;

	assign pready = 1'b1;
	assign prdata = {16'd0, vol_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vol_q <= '0;
		else if (psel && penable && pwrite && paddr == 1'b0)
			vol_q <= pwdata[15:0];
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign layout_ok = (channel_count == CH_MONO) || (channel_count == CH_STEREO && !looping);
	assign last_slot = (slot_q == SLOT_BITS'(VOICE_SLOTS - 1));

	always_comb begin
		free_slot = '0;
		any_free = 1'b0;
		for (int i = VOICE_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_slot = SLOT_BITS'(i);
				any_free = 1'b1;
			end
		end
	end

	assign sc = scale(s_rd, vol_q);
	// one bit of headroom so a stereo cursor passing the top length still ends the clip
	assign cur_next = {1'b0, vr.cursor}
		+ (stereo_q[slot_q] ? (LEN_BITS+1)'(2) : (LEN_BITS+1)'(1));
	assign cur_end = (cur_next >= {1'b0, vr.length});

	mvsm_sample_ram u_sram (.clk(clk), .we(s_we), .addr(s_addr), .wdata(sample_value),
		.rdata(s_rd));
	mvsm_voice_ram u_vram (.clk(clk), .we(v_we), .addr(v_addr), .wdata(vw), .rdata(vr));

	always_comb begin
		state_d = state_q;
		s_we = 1'b0;
		s_addr = address[SAMPLE_ADDR_BITS-1:0];
		v_we = 1'b0;
		v_addr = slot_q;
		vw.start = SAMPLE_ADDR_BITS'(address);
		vw.length = clip_length;
		vw.cursor = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action)
						ACT_WRITE: s_we = 1'b1;
						ACT_START: begin
							v_addr = free_slot;
							v_we = layout_ok && any_free;
							state_d = S_OUT;
						end
						ACT_MIX: begin
							v_addr = '0;
							state_d = S_READ;
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				// descriptor arrives next cycle
				state_d = busy_q[slot_q] ? S_LEFT : S_DONE;
			end
			S_LEFT: begin
				s_addr = vr.start + vr.cursor[SAMPLE_ADDR_BITS-1:0];
				state_d = S_RIGHT;
			end
			S_RIGHT: begin
				s_addr = vr.start + vr.cursor[SAMPLE_ADDR_BITS-1:0] + 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				vw = vr;
				vw.cursor = (cur_end && loops_q[slot_q]) ? '0 : cur_next[LEN_BITS-1:0];
				v_we = busy_q[slot_q];
				if (last_slot)
					state_d = S_OUT;
				else
					state_d = S_READ;
			end
			S_OUT: begin
				if (!out_stall)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= '0;
			stereo_q <= '0;
			loops_q <= '0;
			slot_q <= '0;
			status <= ST_MIXED;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					slot_q <= '0;
					if (accept && action == ACT_START) begin
						if (!layout_ok)
							status <= ST_LAYOUT;
						else if (!any_free)
							status <= ST_FULL;
						else begin
							status <= ST_START;
							busy_q[free_slot] <= 1'b1;
							stereo_q[free_slot] <= (channel_count == CH_STEREO);
							loops_q[free_slot] <= looping;
						end
					end else if (accept && action == ACT_MIX)
						status <= ST_MIXED;
				end
				S_DONE: begin
					if (busy_q[slot_q] && cur_end && !loops_q[slot_q])
						busy_q[slot_q] <= 1'b0;
					slot_q <= slot_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// sample read lands in the cycle after its address
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			acc_l_q <= ACC_BITS'(bed_left);
			acc_r_q <= ACC_BITS'(bed_right);
		end else if (state_q == S_RIGHT) begin
			acc_l_q <= acc_l_q + sc;
			if (!stereo_q[slot_q])
				acc_r_q <= acc_r_q + sc;
		end else if (state_q == S_DONE && busy_q[slot_q] && stereo_q[slot_q])
			acc_r_q <= acc_r_q + sc;
	end

	assign out_valid = (state_q == S_OUT);
	assign mix_left  = (status == ST_MIXED) ? sat32(acc_l_q) : 32'sd0;
	assign mix_right = (status == ST_MIXED) ? sat32(acc_r_q) : 32'sd0;
endmodule

// File: hw/rtl/mvsm_checker.sv
// ---------------------------------------------------------------------------
// mvsm_checker
// Port-level checks of the mixer handshake and result codes.
// ---------------------------------------------------------------------------
module mvsm_checker
	import mvsm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  action,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] mix_left,
	input logic        pready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(mix_left))
		else $error("result changed while stalled");
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");
	a_start_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_START |=> out_valid)
		else $error("start result missing");
	a_start_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_MIXED |-> mix_left == 32'd0)
		else $error("non-mix result carries data");
	a_ready: assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind multi_voice_sample_mixer mvsm_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall), .action(action), .out_valid(out_valid),
	.out_stall(out_stall), .status(status), .mix_left(mix_left), .pready(pready));

// File: tb/multi_voice_sample_mixer_tb.sv
// ---------------------------------------------------------------------------
// multi_voice_sample_mixer_tb
// Drives sample writes, voice starts and frame mixes into the mixer, predicts
// every result from a local copy of the sample memory and voice table, and
// compares each result in order. Master volume is set over APB per phase.
// ---------------------------------------------------------------------------
module multi_voice_sample_mixer_tb;
	import mvsm_pkg::*;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] left;
		logic [31:0] right;
	} frame_result_t;

	class mix_scoreboard;
		logic signed [15:0] store [int];
		bit                 busy [VOICE_SLOTS];
		bit                 stereo [VOICE_SLOTS];
		bit                 loops [VOICE_SLOTS];
		logic [15:0]        vstart [VOICE_SLOTS];
		logic [16:0]        vlen [VOICE_SLOTS];
		logic [31:0]        vcur [VOICE_SLOTS];
		logic [15:0]        volume;
		frame_result_t      pending [$];
		int                 mixes, starts, fulls, layouts;

		function longint gain(logic [31:0] a);
			longint p;
			logic [15:0] ad;
			ad = a[15:0];
			p = store.exists(ad) ? longint'(store[ad]) : 0;
			p = p * longint'(volume);
			return (p < 0) ? -((-p) / 32768) : p / 32768;
		endfunction

		function logic [31:0] clamp(longint v);
			if (v > 64'sd2147483647) return 32'h7FFFFFFF;
			if (v < -64'sd2147483648) return 32'h80000000;
			return v[31:0];
		endfunction

		function void note_request(logic [1:0] act, logic [15:0] adr, logic signed [15:0] smp,
			logic [16:0] len, logic [2:0] ch, logic lp, logic signed [31:0] bl,
			logic signed [31:0] br);
			frame_result_t r;
			longint l, rt, s;
			int slot;
			r.left = 0;
			r.right = 0;
			if (act == ACT_WRITE) begin
				store[adr] = smp;
				return;
			end
			if (act == ACT_START) begin
				slot = -1;
				if (!(ch == CH_MONO || (ch == CH_STEREO && !lp))) begin
					r.status = ST_LAYOUT;
					layouts++;
				end else begin
					for (int i = 0; i < VOICE_SLOTS; i++)
						if (!busy[i] && slot < 0) slot = i;
					if (slot < 0) begin
						r.status = ST_FULL;
						fulls++;
					end else begin
						busy[slot] = 1;
						stereo[slot] = (ch == CH_STEREO);
						loops[slot] = lp;
						vstart[slot] = adr;
						vlen[slot] = len;
						vcur[slot] = 0;
						r.status = ST_START;
						starts++;
					end
				end
				pending.push_back(r);
				return;
			end
			if (act == ACT_MIX) begin
				l = bl;
				rt = br;
				for (int i = 0; i < VOICE_SLOTS; i++) begin
					if (!busy[i]) continue;
					if (stereo[i]) begin
						l += gain(vstart[i] + vcur[i]);
						rt += gain(vstart[i] + vcur[i] + 1);
						vcur[i] += 2;
					end else begin
						s = gain(vstart[i] + vcur[i]);
						l += s;
						rt += s;
						vcur[i] += 1;
					end
					if (vcur[i] >= vlen[i]) begin
						if (loops[i] && !stereo[i]) vcur[i] = 0;
						else busy[i] = 0;
					end
				end
				r.status = ST_MIXED;
				r.left = clamp(l);
				r.right = clamp(rt);
				mixes++;
				pending.push_back(r);
			end
		endfunction

		function bit check_result(logic [1:0] st, logic [31:0] ml, logic [31:0] mr,
			output string why);
			frame_result_t e;
			if (pending.size() == 0) begin
				why = "result with nothing expected";
				return 0;
			end
			e = pending.pop_front();
			if (st !== e.status || ml !== e.left || mr !== e.right) begin
				$sformat(why, "got %0d/%h/%h want %0d/%h/%h", st, ml, mr,
					e.status, e.left, e.right);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [0:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic [1:0] action = 0;
	logic [15:0] address = 0;
	logic signed [15:0] sample_value = 0;
	logic [16:0] clip_length = 0;
	logic [2:0] channel_count = 0;
	logic looping = 0;
	logic signed [31:0] bed_left = 0, bed_right = 0;
	logic out_valid, out_stall = 0;
	logic [1:0] status;
	logic signed [31:0] mix_left, mix_right;

	mix_scoreboard board = new();
	int errors = 0;
	int written [$];
	bit stall_on = 1;

	multi_voice_sample_mixer dut (.*);

	always #10 clk = ~clk;

	task report_mismatch(string why);
		$display("mismatch at %0t: %s", $realtime, why);
		errors++;
	endtask

	// check each result as it leaves the block
	always @(posedge clk) begin
		string why;
		if (arst_n && out_valid && !out_stall)
			if (!board.check_result(status, mix_left, mix_right, why)) report_mismatch(why);
	end

	// receiver back-pressure: runs of stalls, with quiet stretches
	always @(negedge clk) begin
		if (!stall_on) out_stall <= 0;
		else case ($urandom_range(0, 3))
			0: out_stall <= 1;
			1: out_stall <= ($urandom_range(0, 7) == 0);
			default: out_stall <= out_stall & ($urandom_range(0, 1) == 1);
		endcase
	end

	task set_volume(logic [15:0] v);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= {16'd0, v};
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		board.volume = v;
	endtask

	task send(logic [1:0] act, logic [15:0] adr, logic signed [15:0] smp,
		logic [16:0] len, logic [2:0] ch, logic lp, logic signed [31:0] bl,
		logic signed [31:0] br);
		action <= act; address <= adr; sample_value <= smp; clip_length <= len;
		channel_count <= ch; looping <= lp; bed_left <= bl; bed_right <= br;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(act, adr, smp, len, ch, lp, bl, br);
		if (act == ACT_WRITE) written.push_back(adr);
		@(negedge clk);
	endtask

	task pause_gap;
		in_valid <= 0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task drain;
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function logic [15:0] known_addr();
		return written[$urandom_range(0, written.size() - 1)];
	endfunction

	// start a voice only over written words; length kept so every read is known
	task random_voice;
		int n, a, stereo_sel;
		logic [2:0] ch;
		logic lp;
		stereo_sel = $urandom_range(0, 2);
		ch = (stereo_sel == 0) ? CH_STEREO : CH_MONO;
		lp = (ch == CH_MONO) && $urandom_range(0, 1);
		n = $urandom_range(1, 6);
		a = $urandom;
		for (int k = 0; k < n + 1; k++)
			send(ACT_WRITE, 16'(a + k), 16'($urandom), 0, 0, 0, 0, 0);
		send(ACT_START, 16'(a), 0, 17'(($urandom_range(0, 9) == 0) ? 0 : n), ch, lp, 0, 0);
	endtask

	task random_item;
		int r;
		logic [2:0] ch;
		logic lp;
		r = $urandom_range(0, 99);
		ch = 3'($urandom);
		lp = 1'($urandom);
		// a stereo one-shot here would read the word after the known one
		if (ch == CH_STEREO) lp = 1'b1;
		if (r < 15) random_voice();
		else if (r < 25) send(ACT_WRITE, 16'($urandom), 16'($urandom), 17'($urandom),
			3'($urandom), 1'($urandom), $urandom, $urandom);
		else if (r < 32) send(ACT_START, known_addr(), 0, 0, ch, lp, 0, 0);
		else if (r < 35) send(2'd3, 16'($urandom), 16'($urandom), 17'($urandom),
			3'($urandom), 1'($urandom), $urandom, $urandom);
		else send(ACT_MIX, 16'($urandom), 16'($urandom), 17'($urandom), 3'($urandom),
			1'($urandom), ($urandom_range(0, 4) == 0) ? 32'h7FFFFFF0 : $urandom,
			($urandom_range(0, 4) == 0) ? 32'h80000010 : $urandom);
	endtask

	initial begin
		logic [15:0] vols [4];
		vols = '{16'd32768, 16'd0, 16'd65535, 16'd16384};
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		set_volume(16'd32768);
		// directed: extremes, layouts, odd stereo, zero length, full table
		send(ACT_WRITE, 16'hFFFF, 16'sh7FFF, 0, 0, 0, 0, 0);
		send(ACT_WRITE, 16'h0000, -16'sd32768, 0, 0, 0, 0, 0);
		send(ACT_WRITE, 16'h0001, 16'sd1, 0, 0, 0, 0, 0);
		send(ACT_WRITE, 16'h0002, -16'sd1, 0, 0, 0, 0, 0);
		for (int k = 3; k < 6; k++) send(ACT_WRITE, 16'(k), 16'(k * 4099), 0, 0, 0, 0, 0);
		send(ACT_START, 16'hFFFF, 0, 17'd3, CH_STEREO, 0, 0, 0);
		send(ACT_START, 16'h0000, 0, 17'd0, CH_MONO, 1, 0, 0);
		send(ACT_START, 16'h0001, 0, 17'd3, CH_MONO, 0, 0, 0);
		send(ACT_START, 16'h0000, 0, 17'd0, CH_MONO, 0, 0, 0);
		send(ACT_START, 16'h0000, 0, 17'd1, CH_STEREO, 1, 0, 0);
		send(ACT_START, 16'h0000, 0, 17'd1, 3'd0, 0, 0, 0);
		send(ACT_START, 16'h0000, 0, 17'd1, 3'd7, 1, 0, 0);
		send(2'd3, 16'hFFFF, -16'sd1, 17'h1FFFF, 3'd7, 1, -1, -1);
		send(ACT_MIX, 0, 0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000);
		send(ACT_MIX, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF);
		send(ACT_MIX, 0, 0, 0, 0, 0, 0, 0);
		for (int k = 0; k < 16; k++) send(ACT_START, 16'h0001, 0, 17'd5, CH_MONO, 0, 0, 0);
		send(ACT_MIX, 0, 0, 0, 0, 0, 32'sh7FFFFFF0, -32'sd5);
		drain();
		// random phases, one volume each; hold off mid-phase at least once per phase
		for (int ph = 0; ph < 4; ph++) begin
			set_volume(vols[ph]);
			stall_on = (ph != 2);
			for (int n = 0; n < 110; ) begin
				repeat ($urandom_range(1, 12)) begin
					random_item();
					n++;
				end
				if (n > 50 && n < 64) drain();
				else if ($urandom_range(0, 2) != 0) pause_gap();
			end
			drain();
		end
		$display("covered %0d mixes, %0d starts, %0d full-table and %0d layout rejects",
			board.mixes, board.starts, board.fulls, board.layouts);
		$display("volume settings unity, zero, maximum and half were exercised");
		if (errors == 0 && board.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#40000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule

// File: files.f
hw/rtl/mvsm_pkg.sv
hw/rtl/mvsm_sample_ram.sv
hw/rtl/mvsm_voice_ram.sv
hw/rtl/multi_voice_sample_mixer.sv
hw/rtl/mvsm_checker.sv
tb/multi_voice_sample_mixer_tb.sv
